// ----- hw/rtl/rigid_pose_accumulator_core_assert.svh -----
// ----------------------------------------------------------------------------
// Rigid pose accumulator assertion macros
// Shared concurrent assertion forms for the accumulator RTL.
// ----------------------------------------------------------------------------
`ifndef RIGID_POSE_ACCUMULATOR_CORE_ASSERT_SVH
`define RIGID_POSE_ACCUMULATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RPA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rpa assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RPA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rpa assertion failed");

`endif

// ----- hw/rtl/rpa_pkg.sv -----
// ----------------------------------------------------------------------------
// Rigid pose accumulator package
// Types, constants and coefficient tables shared by the accumulator RTL.
// ----------------------------------------------------------------------------
package rpa_pkg;

  localparam int QUAT_FRAC_BITS = 30;
  localparam int QW = QUAT_FRAC_BITS + 2;

  localparam logic signed [65:0] ONE2    = 66'sd1 << (2 * QUAT_FRAC_BITS);
  localparam logic signed [65:0] ONE_W   = 66'sd1 << QUAT_FRAC_BITS;
  localparam logic signed [65:0] HALF_Q  = 66'sd1 << (QUAT_FRAC_BITS - 1);
  localparam logic signed [32:0] ONE_Q   = 33'sd1 << QUAT_FRAC_BITS;
  localparam logic signed [65:0] NORM_HI = 66'sd1 << 30;
  localparam logic signed [65:0] NORM_LO = 66'sd1 << 29;
  localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
  localparam logic signed [65:0] S32_MIN = -66'sd2147483648;

  localparam logic [1:0] FUNC_LOAD    = 2'd0;
  localparam logic [1:0] FUNC_COMPOSE = 2'd1;
  localparam logic [1:0] FUNC_INVERT  = 2'd2;

  // Sign of each Hamilton product term, indexed by component and term.
  localparam logic [15:0] HAM_NEG = 16'h428E;
  // Diagonal matrix entries start from one squared.
  localparam logic [8:0]  MAT_ONE = 9'b1_0001_0001;

  typedef enum logic [4:0] {
    OP_NOP, OP_ACPT, OP_MUL, OP_ACC, OP_WT, OP_WM, OP_WR, OP_SHR, OP_SHL,
    OP_ZQ, OP_SQI, OP_SQS, OP_DVI, OP_DVS, OP_DVW, OP_CONJ, OP_FIN
  } op_e;

  typedef enum logic [2:0] {
    SRC_AQ, SRC_IQ, SRC_RQ, SRC_T, SRC_M, SRC_RV
  } src_e;

  typedef struct packed {
    src_e       src;
    logic [3:0] idx;
  } opnd_t;

  typedef struct packed {
    op_e        op;
    opnd_t      a;
    opnd_t      b;
    logic       neg;
    logic       dbl;
    logic       first;
    logic       one2;
    logic [4:0] idx;
  } cmd_t;

  typedef struct packed {
    logic       t_big;
    logic       t_low;
    logic       t_zero;
    logic [1:0] func;
  } stat_t;

  typedef struct packed {
    logic [1:0]       func;
    logic [2:0][31:0] p;
    logic [3:0][31:0] q;
  } in_beat_t;

  typedef struct packed {
    logic [2:0][31:0] p;
    logic [3:0][31:0] q;
  } pose_t;

  typedef struct packed {
    logic [1:0] a;
    logic [1:0] b;
    logic       neg;
  } mterm_t;

  function automatic mterm_t mat_term(input logic [3:0] e, input logic t);
    mterm_t m;
    case (e)
      4'd0: m = t ? '{a: 2'd3, b: 2'd3, neg: 1'b1} : '{a: 2'd2, b: 2'd2, neg: 1'b1};
      4'd1: m = t ? '{a: 2'd3, b: 2'd0, neg: 1'b1} : '{a: 2'd1, b: 2'd2, neg: 1'b0};
      4'd2: m = t ? '{a: 2'd2, b: 2'd0, neg: 1'b0} : '{a: 2'd1, b: 2'd3, neg: 1'b0};
      4'd3: m = t ? '{a: 2'd3, b: 2'd0, neg: 1'b0} : '{a: 2'd1, b: 2'd2, neg: 1'b0};
      4'd4: m = t ? '{a: 2'd3, b: 2'd3, neg: 1'b1} : '{a: 2'd1, b: 2'd1, neg: 1'b1};
      4'd5: m = t ? '{a: 2'd1, b: 2'd0, neg: 1'b1} : '{a: 2'd2, b: 2'd3, neg: 1'b0};
      4'd6: m = t ? '{a: 2'd2, b: 2'd0, neg: 1'b1} : '{a: 2'd1, b: 2'd3, neg: 1'b0};
      4'd7: m = t ? '{a: 2'd1, b: 2'd0, neg: 1'b0} : '{a: 2'd2, b: 2'd3, neg: 1'b0};
      4'd8: m = t ? '{a: 2'd2, b: 2'd2, neg: 1'b1} : '{a: 2'd1, b: 2'd1, neg: 1'b1};
      default: m = '{a: 2'd0, b: 2'd0, neg: 1'b0};
    endcase
    return m;
  endfunction

  function automatic logic [3:0] dot_m(input logic [3:0] e, input logic [1:0] t);
    logic [3:0] k;
    k = e - 4'd9;
    return (k << 1) + k + {2'b00, t};
  endfunction

  function automatic logic signed [65:0] round_q(input logic signed [65:0] x);
    return (x + HALF_Q) >>> QUAT_FRAC_BITS;
  endfunction

  function automatic logic [31:0] clamp_q(input logic signed [65:0] x);
    logic [31:0] r;
    if (x > ONE_W) r = ONE_W[31:0];
    else if (x < -ONE_W) r = 32'(-ONE_W);
    else r = x[31:0];
    return r;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [65:0] x);
    logic [31:0] r;
    if (x > S32_MAX) r = S32_MAX[31:0];
    else if (x < S32_MIN) r = S32_MIN[31:0];
    else r = x[31:0];
    return r;
  endfunction

endpackage

// ----- hw/rtl/rpa_if.sv -----
// ----------------------------------------------------------------------------
// Rigid pose accumulator channels
// Valid/ready channels for input poses and accumulated result poses.
// ----------------------------------------------------------------------------
interface rpa_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic signed [31:0] in_px;
  logic signed [31:0] in_py;
  logic signed [31:0] in_pz;
  logic signed [31:0] in_qw;
  logic signed [31:0] in_qx;
  logic signed [31:0] in_qy;
  logic signed [31:0] in_qz;

  modport source (output valid, func, in_px, in_py, in_pz, in_qw, in_qx, in_qy, in_qz,
                  input ready);
  modport sink (input valid, func, in_px, in_py, in_pz, in_qw, in_qx, in_qy, in_qz,
                output ready);
endinterface

interface rpa_out_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] out_px;
  logic signed [31:0] out_py;
  logic signed [31:0] out_pz;
  logic signed [31:0] out_qw;
  logic signed [31:0] out_qx;
  logic signed [31:0] out_qy;
  logic signed [31:0] out_qz;

  modport source (output valid, out_px, out_py, out_pz, out_qw, out_qx, out_qy, out_qz,
                  input ready);
  modport sink (input valid, out_px, out_py, out_pz, out_qw, out_qx, out_qy, out_qz,
                output ready);
endinterface

// ----- hw/rtl/rigid_pose_accumulator_core.sv -----
// ----------------------------------------------------------------------------
// Rigid pose accumulator core
// Accumulates a rigid pose under load, compose and invert operations.
// ----------------------------------------------------------------------------
//  channel   direction   beat contents
//  in_i      sink        func, in_px/py/pz (Q16.16), in_qw/qx/qy/qz (Q2.30)
//  out_o     source      out_px/py/pz (Q16.16), out_qw/qx/qy/qz (Q2.30)
//
// One input beat is worked on at a time and gives one output beat. Load and compose
// normalize the quaternion with one shift per step, and skip the square root and divide
// for a zero quaternion or a zero product; invert needs neither. The 32-step square root,
// the restoring divider (run once per component) and the shared 32x32 multiplier set
// how long each operation runs.
// Reset returns the pose to the origin with the identity quaternion.
// A new beat is taken while a result waits; its result is held until taken.
// ----------------------------------------------------------------------------
module rigid_pose_accumulator_core import rpa_pkg::*; (
  input logic   clk_i,
  input logic   rst_ni,
  rpa_in_if.sink     in_i,
  rpa_out_if.source  out_o
);

  cmd_t     cmd;
  stat_t    stat;
  in_beat_t beat;
  pose_t    pose;

  assign beat.func = in_i.func;
  assign beat.p[0] = in_i.in_px;
  assign beat.p[1] = in_i.in_py;
  assign beat.p[2] = in_i.in_pz;
  assign beat.q[0] = in_i.in_qw;
  assign beat.q[1] = in_i.in_qx;
  assign beat.q[2] = in_i.in_qy;
  assign beat.q[3] = in_i.in_qz;

  assign out_o.out_px = pose.p[0];
  assign out_o.out_py = pose.p[1];
  assign out_o.out_pz = pose.p[2];
  assign out_o.out_qw = pose.q[0];
  assign out_o.out_qx = pose.q[1];
  assign out_o.out_qy = pose.q[2];
  assign out_o.out_qz = pose.q[3];

  rpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rpa_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .in_i   (beat),
    .pose_o (pose),
    .stat_o (stat)
  );

endmodule

// ----- hw/rtl/rpa_datapath.sv -----
// ----------------------------------------------------------------------------
// Rigid pose accumulator datapath
// Pose registers, shared multiplier, accumulator, square root and divider.
// ----------------------------------------------------------------------------
module rpa_datapath import rpa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cmd_t     cmd_i,
  input  in_beat_t in_i,
  output pose_t    pose_o,
  output stat_t    stat_o
);

  logic signed [31:0] acc_p_q [3];
  logic signed [31:0] acc_q_q [4];
  logic signed [31:0] ip_q [3];
  logic signed [31:0] iq_q [4];
  logic [1:0]         func_q;
  logic signed [65:0] t_q [4];
  logic signed [31:0] m_q [9];
  logic signed [65:0] r_q [3];
  logic signed [31:0] nq_q [4];
  logic signed [63:0] prod_q;
  logic signed [65:0] sum_q;
  logic [63:0]        sx_q;
  logic [63:0]        sr_q;
  logic [63:0]        rem_q;
  logic [31:0]        quo_q;

  logic signed [31:0] rq [4];
  logic signed [31:0] rv [3];
  logic signed [31:0] opv [2];
  opnd_t              sel [2];
  logic signed [63:0] prod_d;
  logic signed [65:0] sum_d;
  logic [63:0]        bitv;
  logic [63:0]        trial;
  logic [63:0]        dsh;
  logic [63:0]        tabs;

  always_comb begin
    logic signed [32:0] rqx;
    logic signed [65:0] x;
    logic signed [65:0] base;
    logic signed [65:0] tsel;
    for (int i = 0; i < 4; i++) begin
      rqx = (func_q == FUNC_INVERT && i != 0) ? -33'(acc_q_q[i]) : 33'(acc_q_q[i]);
      if (rqx > ONE_Q) rq[i] = ONE_Q[31:0];
      else if (rqx < -ONE_Q) rq[i] = 32'(-ONE_Q);
      else rq[i] = rqx[31:0];
    end
    for (int i = 0; i < 3; i++) begin
      rv[i] = (func_q == FUNC_INVERT) ? acc_p_q[i] : ip_q[i];
    end

    sel[0] = cmd_i.a;
    sel[1] = cmd_i.b;
    for (int k = 0; k < 2; k++) begin
      case (sel[k].src)
        SRC_AQ: opv[k] = acc_q_q[sel[k].idx[1:0]];
        SRC_IQ: opv[k] = iq_q[sel[k].idx[1:0]];
        SRC_RQ: opv[k] = rq[sel[k].idx[1:0]];
        SRC_T:  opv[k] = t_q[sel[k].idx[1:0]][31:0];
        SRC_M:  opv[k] = (sel[k].idx <= 4'd8) ? m_q[sel[k].idx] : '0;
        SRC_RV: opv[k] = (sel[k].idx[1:0] != 2'd3) ? rv[sel[k].idx[1:0]] : '0;
        default: opv[k] = '0;
      endcase
    end
    prod_d = opv[0] * opv[1];

    x = 66'(prod_q);
    if (cmd_i.dbl) x = x <<< 1;
    base = cmd_i.first ? (cmd_i.one2 ? ONE2 : '0) : sum_q;
    sum_d = base + (cmd_i.neg ? -x : x);

    bitv  = 64'd1 << {cmd_i.idx, 1'b0};
    trial = sr_q + bitv;
    dsh   = sr_q << cmd_i.idx;
    tsel  = t_q[cmd_i.idx[1:0]];
    tabs  = tsel[65] ? 64'(-tsel) : 64'(tsel);

    stat_o.t_big  = 1'b0;
    stat_o.t_low  = 1'b1;
    stat_o.t_zero = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (t_q[i] >= NORM_HI || t_q[i] <= -NORM_HI) stat_o.t_big = 1'b1;
      if (!(t_q[i] < NORM_LO && t_q[i] > -NORM_LO)) stat_o.t_low = 1'b0;
      if (t_q[i] != '0) stat_o.t_zero = 1'b0;
    end
    stat_o.func = func_q;

    for (int i = 0; i < 3; i++) pose_o.p[i] = acc_p_q[i];
    for (int i = 0; i < 4; i++) pose_o.q[i] = acc_q_q[i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) acc_p_q[i] <= '0;
      acc_q_q[0] <= ONE_Q[31:0];
      for (int i = 1; i < 4; i++) acc_q_q[i] <= '0;
    end else if (cmd_i.op == OP_FIN) begin
      case (func_q)
        FUNC_LOAD: begin
          acc_p_q <= ip_q;
          acc_q_q <= nq_q;
        end
        FUNC_COMPOSE: begin
          for (int i = 0; i < 3; i++) acc_p_q[i] <= sat32(r_q[i] + 66'(acc_p_q[i]));
          acc_q_q <= nq_q;
        end
        FUNC_INVERT: begin
          for (int i = 0; i < 3; i++) acc_p_q[i] <= sat32(-r_q[i]);
          acc_q_q <= nq_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_ACPT: begin
        func_q <= in_i.func;
        for (int i = 0; i < 3; i++) ip_q[i] <= in_i.p[i];
        for (int i = 0; i < 4; i++) begin
          iq_q[i] <= in_i.q[i];
          t_q[i]  <= 66'($signed(in_i.q[i]));
        end
      end
      OP_MUL: prod_q <= prod_d;
      OP_ACC: sum_q <= sum_d;
      OP_WT:  t_q[cmd_i.idx[1:0]] <= sum_q >>> 2;
      OP_WM: begin
        if (cmd_i.idx[3:0] <= 4'd8) m_q[cmd_i.idx[3:0]] <= clamp_q(round_q(sum_q));
      end
      OP_WR: begin
        if (cmd_i.idx[1:0] != 2'd3) r_q[cmd_i.idx[1:0]] <= round_q(sum_q);
      end
      OP_SHR: for (int i = 0; i < 4; i++) t_q[i] <= t_q[i] >>> 1;
      OP_SHL: for (int i = 0; i < 4; i++) t_q[i] <= t_q[i] <<< 1;
      OP_ZQ:  for (int i = 0; i < 4; i++) nq_q[i] <= '0;
      OP_SQI: begin
        sx_q <= sum_q[63:0];
        sr_q <= '0;
      end
      OP_SQS: begin
        if (sx_q >= trial) begin
          sx_q <= sx_q - trial;
          sr_q <= (sr_q >> 1) + bitv;
        end else begin
          sr_q <= sr_q >> 1;
        end
      end
      OP_DVI: begin
        rem_q <= (tabs << QUAT_FRAC_BITS) + (sr_q >> 1);
        quo_q <= '0;
      end
      OP_DVS: begin
        if (rem_q >= dsh) begin
          rem_q <= rem_q - dsh;
          quo_q[cmd_i.idx] <= 1'b1;
        end
      end
      OP_DVW: nq_q[cmd_i.idx[1:0]] <= t_q[cmd_i.idx[1:0]][65] ? -quo_q : quo_q;
      OP_CONJ: begin
        nq_q[0] <= acc_q_q[0];
        for (int i = 1; i < 4; i++) nq_q[i] <= -acc_q_q[i];
      end
      default: ;
    endcase
  end

endmodule

// ----- hw/rtl/rpa_ctrl.sv -----
// ----------------------------------------------------------------------------
// Rigid pose accumulator controller
// Sequences the datapath through product, normalize, square root, divide and rotate phases.
// ----------------------------------------------------------------------------
module rpa_ctrl import rpa_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  `include "rigid_pose_accumulator_core_assert.svh"

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_DISP = 5'd1;
  localparam logic [4:0] S_HMUL = 5'd2;
  localparam logic [4:0] S_HACC = 5'd3;
  localparam logic [4:0] S_HWT  = 5'd4;
  localparam logic [4:0] S_NSHR = 5'd5;
  localparam logic [4:0] S_NSHL = 5'd6;
  localparam logic [4:0] S_SMUL = 5'd7;
  localparam logic [4:0] S_SACC = 5'd8;
  localparam logic [4:0] S_SQI  = 5'd9;
  localparam logic [4:0] S_SQRT = 5'd10;
  localparam logic [4:0] S_DVI  = 5'd11;
  localparam logic [4:0] S_DVS  = 5'd12;
  localparam logic [4:0] S_DVW  = 5'd13;
  localparam logic [4:0] S_CONJ = 5'd14;
  localparam logic [4:0] S_RMUL = 5'd15;
  localparam logic [4:0] S_RACC = 5'd16;
  localparam logic [4:0] S_RWR  = 5'd17;
  localparam logic [4:0] S_FIN  = 5'd18;

  logic [4:0] state_q, state_d;
  logic [3:0] ent_q, ent_d;
  logic [1:0] term_q, term_d;
  logic [4:0] cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;
  logic       mat;
  mterm_t     mt;

  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    ent_d   = ent_q;
    term_d  = term_q;
    cnt_d   = cnt_q;
    cmd_o.op    = OP_NOP;
    cmd_o.a     = '{src: SRC_AQ, idx: 4'd0};
    cmd_o.b     = '{src: SRC_AQ, idx: 4'd0};
    cmd_o.neg   = 1'b0;
    cmd_o.dbl   = 1'b0;
    cmd_o.first = 1'b0;
    cmd_o.one2  = 1'b0;
    cmd_o.idx   = 5'd0;
    in_ready_o  = (state_q == S_IDLE);
    mat = (ent_q < 4'd9);
    mt  = mat_term(ent_q, term_q[0]);

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_ACPT;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        ent_d  = 4'd0;
        term_d = 2'd0;
        case (stat_i.func)
          FUNC_LOAD:    state_d = S_NSHR;
          FUNC_COMPOSE: state_d = S_HMUL;
          FUNC_INVERT:  state_d = S_CONJ;
          default:      state_d = S_FIN;
        endcase
      end
      S_HMUL: begin
        cmd_o.op = OP_MUL;
        cmd_o.a  = '{src: SRC_AQ, idx: {2'b00, term_q}};
        cmd_o.b  = '{src: SRC_IQ, idx: {2'b00, ent_q[1:0] ^ term_q}};
        state_d  = S_HACC;
      end
      S_HACC: begin
        cmd_o.op    = OP_ACC;
        cmd_o.first = (term_q == 2'd0);
        cmd_o.neg   = HAM_NEG[{ent_q[1:0], term_q}];
        if (term_q == 2'd3) begin
          state_d = S_HWT;
        end else begin
          term_d  = term_q + 2'd1;
          state_d = S_HMUL;
        end
      end
      S_HWT: begin
        cmd_o.op  = OP_WT;
        cmd_o.idx = {3'b000, ent_q[1:0]};
        term_d    = 2'd0;
        if (ent_q == 4'd3) begin
          ent_d   = 4'd0;
          state_d = S_NSHR;
        end else begin
          ent_d   = ent_q + 4'd1;
          state_d = S_HMUL;
        end
      end
      S_NSHR: begin
        if (stat_i.t_big) begin
          cmd_o.op = OP_SHR;
        end else if (stat_i.t_zero) begin
          cmd_o.op = OP_ZQ;
          ent_d    = 4'd0;
          term_d   = 2'd0;
          state_d  = (stat_i.func == FUNC_COMPOSE) ? S_RMUL : S_FIN;
        end else begin
          state_d = S_NSHL;
        end
      end
      S_NSHL: begin
        if (stat_i.t_low) begin
          cmd_o.op = OP_SHL;
        end else begin
          term_d  = 2'd0;
          state_d = S_SMUL;
        end
      end
      S_SMUL: begin
        cmd_o.op = OP_MUL;
        cmd_o.a  = '{src: SRC_T, idx: {2'b00, term_q}};
        cmd_o.b  = '{src: SRC_T, idx: {2'b00, term_q}};
        state_d  = S_SACC;
      end
      S_SACC: begin
        cmd_o.op    = OP_ACC;
        cmd_o.first = (term_q == 2'd0);
        if (term_q == 2'd3) begin
          state_d = S_SQI;
        end else begin
          term_d  = term_q + 2'd1;
          state_d = S_SMUL;
        end
      end
      S_SQI: begin
        cmd_o.op = OP_SQI;
        cnt_d    = 5'd31;
        state_d  = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.op  = OP_SQS;
        cmd_o.idx = cnt_q;
        if (cnt_q == 5'd0) begin
          ent_d   = 4'd0;
          state_d = S_DVI;
        end else begin
          cnt_d = cnt_q - 5'd1;
        end
      end
      S_DVI: begin
        cmd_o.op  = OP_DVI;
        cmd_o.idx = {3'b000, ent_q[1:0]};
        cnt_d     = 5'(QW - 1);
        state_d   = S_DVS;
      end
      S_DVS: begin
        cmd_o.op  = OP_DVS;
        cmd_o.idx = cnt_q;
        if (cnt_q == 5'd0) begin
          state_d = S_DVW;
        end else begin
          cnt_d = cnt_q - 5'd1;
        end
      end
      S_DVW: begin
        cmd_o.op  = OP_DVW;
        cmd_o.idx = {3'b000, ent_q[1:0]};
        if (ent_q == 4'd3) begin
          ent_d   = 4'd0;
          term_d  = 2'd0;
          state_d = (stat_i.func == FUNC_COMPOSE) ? S_RMUL : S_FIN;
        end else begin
          ent_d   = ent_q + 4'd1;
          state_d = S_DVI;
        end
      end
      S_CONJ: begin
        cmd_o.op = OP_CONJ;
        ent_d    = 4'd0;
        term_d   = 2'd0;
        state_d  = S_RMUL;
      end
      S_RMUL: begin
        cmd_o.op = OP_MUL;
        if (mat) begin
          cmd_o.a = '{src: SRC_RQ, idx: {2'b00, mt.a}};
          cmd_o.b = '{src: SRC_RQ, idx: {2'b00, mt.b}};
        end else begin
          cmd_o.a = '{src: SRC_M, idx: dot_m(ent_q, term_q)};
          cmd_o.b = '{src: SRC_RV, idx: {2'b00, term_q}};
        end
        state_d = S_RACC;
      end
      S_RACC: begin
        cmd_o.op    = OP_ACC;
        cmd_o.first = (term_q == 2'd0);
        cmd_o.neg   = mat && mt.neg;
        cmd_o.dbl   = mat;
        cmd_o.one2  = mat && MAT_ONE[ent_q];
        if (mat ? (term_q == 2'd1) : (term_q == 2'd2)) begin
          state_d = S_RWR;
        end else begin
          term_d  = term_q + 2'd1;
          state_d = S_RMUL;
        end
      end
      S_RWR: begin
        if (mat) begin
          cmd_o.op  = OP_WM;
          cmd_o.idx = {1'b0, ent_q};
        end else begin
          cmd_o.op  = OP_WR;
          cmd_o.idx = {1'b0, ent_q - 4'd9};
        end
        term_d = 2'd0;
        if (ent_q == 4'd11) begin
          state_d = S_FIN;
        end else begin
          ent_d   = ent_q + 4'd1;
          state_d = S_RMUL;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op = OP_FIN;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cmd_o.op == OP_FIN) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ent_q       <= 4'd0;
      term_q      <= 2'd0;
      cnt_q       <= 5'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ent_q       <= ent_d;
      term_q      <= term_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  `RPA_ASSERT_NXT(a_accept_dispatch, clk_i, rst_ni, in_valid_i && in_ready_o, state_q == S_DISP)
  `RPA_ASSERT_NXT(a_fin_shows_beat, clk_i, rst_ni, cmd_o.op == OP_FIN, out_valid_q && state_q == S_IDLE)
  `RPA_ASSERT_NXT(a_sqrt_to_div, clk_i, rst_ni, state_q == S_SQRT && cnt_q == 5'd0, state_q == S_DVI && ent_q == 4'd0)
  `RPA_ASSERT_IMP(a_rot_bound, clk_i, rst_ni, state_q == S_RMUL || state_q == S_RACC, ent_q <= 4'd11)

endmodule
